### design/huffman_bit_packer_macros.svh
// ---------------------------------------------------------------------------
// huffman_bit_packer_macros.svh
// Assertion macros for the Huffman bit packer.
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_BIT_PACKER_MACROS_SVH
`define HUFFMAN_BIT_PACKER_MACROS_SVH

`ifndef SYNTHESIS
`define HBP_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("hbp: invariant violated");
`define HBP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hbp: implication violated");
`else
`define HBP_ASSERT_ALWAYS(lbl, expr)
`define HBP_ASSERT_IMPLY(lbl, ante, cons)
`endif

`endif

### design/hbp_pkg.sv
// ---------------------------------------------------------------------------
// hbp_pkg
// Shared types and constants of the Huffman bit packer.
// ---------------------------------------------------------------------------
package hbp_pkg;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    localparam int WORD_BITS = 32;
    localparam int LEN_W     = 6;
    localparam int BYTE_BITS = 8;
    localparam int SYM_BITS  = 8;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // one queued transaction for the packer
    typedef struct packed {
        logic                 flush;
        logic [WORD_BITS-1:0] word;
        logic [LEN_W-1:0]     len;
    } t_hbp_item;

    // packer status seen by the queue and the top level
    typedef struct packed {
        logic pop;
        logic busy;
    } t_hbp_bk_stat;

endpackage

### design/hbp_front.sv
// ---------------------------------------------------------------------------
// hbp_front
// Accepts transactions, writes code table entries, looks up codes for data
// and flush transactions and hands them to the queue.
// ---------------------------------------------------------------------------
module hbp_front #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_kind,
    input  logic [7:0]            i_symbol,
    input  logic [31:0]           i_code_word,
    input  logic [5:0]            i_code_length,
    output logic                  o_item_valid,
    output hbp_pkg::t_hbp_item    o_item,
    input  logic                  i_q_ready
);

    localparam int SYM_W     = $clog2(SYMBOL_COUNT);
    localparam int LEN_LIMIT = (MAX_CODE_LEN < hbp_pkg::WORD_BITS) ?
                               MAX_CODE_LEN : hbp_pkg::WORD_BITS;

    logic [hbp_pkg::WORD_BITS-1:0] r_word_mem [SYMBOL_COUNT];
    logic [hbp_pkg::LEN_W-1:0]     r_len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0]       r_len_vld;

    logic                          r_lk_valid;
    logic                          r_lk_flush;
    logic                          r_lk_inr;
    logic                          r_rd_vld;
    logic [hbp_pkg::WORD_BITS-1:0] r_rd_word;
    logic [hbp_pkg::LEN_W-1:0]     r_rd_len;

    logic                          accept;
    logic                          push;
    logic                          in_range;
    logic                          is_load;
    logic                          is_lookup;
    logic [SYM_W-1:0]              idx;
    logic [hbp_pkg::LEN_W-1:0]     len_sat;

    assign push      = r_lk_valid && i_q_ready;
    assign o_ready   = !r_lk_valid || i_q_ready;
    assign accept    = i_valid && o_ready;
    assign in_range  = (9'(i_symbol) < 9'(SYMBOL_COUNT));
    assign idx       = i_symbol[SYM_W-1:0];
    assign is_load   = accept && (i_kind == hbp_pkg::KIND_LOAD) && in_range;
    assign is_lookup = accept && ((i_kind == hbp_pkg::KIND_DATA) ||
                                  (i_kind == hbp_pkg::KIND_FLUSH));
    assign len_sat   = (i_code_length > hbp_pkg::LEN_W'(LEN_LIMIT)) ?
                       hbp_pkg::LEN_W'(LEN_LIMIT) : i_code_length;

    always_ff @(posedge i_clk) begin
        if (is_load) begin
            r_word_mem[idx] <= i_code_word;
            r_len_mem[idx]  <= len_sat;
        end
        if (is_lookup) begin
            r_rd_word <= r_word_mem[idx];
            r_rd_len  <= r_len_mem[idx];
            r_rd_vld  <= r_len_vld[idx];
            r_lk_inr  <= in_range;
            r_lk_flush <= (i_kind == hbp_pkg::KIND_FLUSH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld  <= '0;
            r_lk_valid <= 1'b0;
        end else begin
            if (is_load) begin
                r_len_vld[idx] <= 1'b1;
            end
            if (is_lookup) begin
                r_lk_valid <= 1'b1;
            end else if (push) begin
                r_lk_valid <= 1'b0;
            end
        end
    end

    assign o_item_valid = r_lk_valid;
    assign o_item.flush = r_lk_flush;
    assign o_item.word  = r_rd_word;
    assign o_item.len   = (r_lk_inr && r_rd_vld) ? r_rd_len : '0;

endmodule

### design/hbp_queue.sv
// ---------------------------------------------------------------------------
// hbp_queue
// Two-entry queue between the lookup front and the bit packer.
// ---------------------------------------------------------------------------
module hbp_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  hbp_pkg::t_hbp_item    i_item,
    output logic                  o_ready,
    output logic                  o_valid,
    output hbp_pkg::t_hbp_item    o_item,
    input  hbp_pkg::t_hbp_bk_stat i_bk_stat
);

    hbp_pkg::t_hbp_item            r_mem [hbp_pkg::Q_DEPTH];
    logic [hbp_pkg::Q_PTR_W-1:0]   r_wr_ptr;
    logic [hbp_pkg::Q_PTR_W-1:0]   r_rd_ptr;
    logic [hbp_pkg::Q_CNT_W-1:0]   r_count;
    logic                          wr_en;
    logic                          rd_en;

    assign o_ready = (r_count != hbp_pkg::Q_CNT_W'(hbp_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && o_ready;
    assign rd_en   = i_bk_stat.pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### design/hbp_back.sv
// ---------------------------------------------------------------------------
// hbp_back
// Bit packer: shifts code bits into the byte accumulator and emits one
// byte per cycle, while the output is ready, through an output register.
// ---------------------------------------------------------------------------
module hbp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    input  hbp_pkg::t_hbp_item    i_item,
    output hbp_pkg::t_hbp_bk_stat o_stat,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_data,
    output logic                  o_last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_bk_state;

    t_bk_state                     r_state, n_state;
    logic [6:0]                    r_acc, n_acc;
    logic [2:0]                    r_pend, n_pend;
    logic [hbp_pkg::WORD_BITS-1:0] r_sh, n_sh;
    logic [hbp_pkg::LEN_W-1:0]     r_rem, n_rem;
    logic                          r_out_valid, n_out_valid;
    logic [7:0]                    r_out_data, n_out_data;
    logic                          r_out_last, n_out_last;

    logic                          out_free;
    logic                          pop;
    logic [3:0]                    need;
    logic [14:0]                   window;
    logic [hbp_pkg::LEN_W-1:0]     rem_after;
    logic [14:0]                   pad_word;

    assign out_free  = !r_out_valid || i_ready;
    assign need      = 4'(hbp_pkg::BYTE_BITS) - {1'b0, r_pend};
    assign window    = {r_acc, r_sh[hbp_pkg::WORD_BITS-1 -: 8]};
    assign rem_after = r_rem - {2'b00, need};
    assign pad_word  = {8'b0, r_acc} << (4'(hbp_pkg::BYTE_BITS) - {1'b0, r_pend});

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_pend      = r_pend;
        n_sh        = r_sh;
        n_rem       = r_rem;
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        pop         = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    if (!i_item.flush) begin
                        pop     = 1'b1;
                        n_sh    = i_item.word <<
                                  (hbp_pkg::LEN_W'(hbp_pkg::WORD_BITS) - i_item.len);
                        n_rem   = i_item.len;
                        n_state = ST_RUN;
                    end else if (r_pend == '0) begin
                        pop    = 1'b1;
                        n_acc  = '0;
                    end else if (out_free) begin
                        pop         = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_data  = pad_word[7:0];
                        n_out_last  = 1'b1;
                        n_acc       = '0;
                        n_pend      = '0;
                    end
                end
            end
            ST_RUN: begin
                if (r_rem >= {2'b00, need}) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_data  = 8'(window >> r_pend);
                        n_out_last  = (rem_after < hbp_pkg::LEN_W'(hbp_pkg::BYTE_BITS));
                        n_acc       = '0;
                        n_pend      = '0;
                        n_sh        = r_sh << need;
                        n_rem       = rem_after;
                        if (rem_after == '0) begin
                            n_state = ST_IDLE;
                        end
                    end
                end else begin
                    // keep the leftover code bits for the next transaction
                    n_acc   = 7'(window >> (4'(hbp_pkg::BYTE_BITS) - {1'b0, r_rem[2:0]}));
                    n_pend  = r_pend + r_rem[2:0];
                    n_rem   = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sh       <= n_sh;
        r_rem      <= n_rem;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stat.pop  = pop;
    assign o_stat.busy = (r_state == ST_RUN);
    assign o_valid     = r_out_valid;
    assign o_data      = r_out_data;
    assign o_last      = r_out_last;

endmodule

### design/huffman_bit_packer.sv
// Path to the first output byte: lookup register, queue, packer shift register, output register.
// Throughput: the front takes new transactions unless its lookup waits on a full queue; the
// packer emits one byte per cycle while the output is ready.
// Reset: synchronous, active low; clears control state, the accumulator and the
// length-table valid bits at once; no clearing pass, transactions accepted right after.
// ---------------------------------------------------------------------------
// huffman_bit_packer
// Huffman encoder back end: code table, lookup front, queue and bit packer.
// ---------------------------------------------------------------------------
`include "huffman_bit_packer_macros.svh"

module huffman_bit_packer #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // symbol[7:0], code_word[39:8], code_length[45:40]
    input  logic [1:0]  i_s_axis_tuser,  // kind[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // packed_byte[7:0]
    output logic        o_m_axis_tlast
);

    logic                  w_fe_valid;
    hbp_pkg::t_hbp_item    w_fe_item;
    logic                  w_q_ready;
    logic                  w_q_valid;
    hbp_pkg::t_hbp_item    w_q_item;
    hbp_pkg::t_hbp_bk_stat w_bk_stat;

    hbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_kind        (i_s_axis_tuser),
        .i_symbol      (i_s_axis_tdata[7:0]),
        .i_code_word   (i_s_axis_tdata[39:8]),
        .i_code_length (i_s_axis_tdata[45:40]),
        .o_item_valid  (w_fe_valid),
        .o_item        (w_fe_item),
        .i_q_ready     (w_q_ready)
    );

    hbp_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_fe_valid),
        .i_item    (w_fe_item),
        .o_ready   (w_q_ready),
        .o_valid   (w_q_valid),
        .o_item    (w_q_item),
        .i_bk_stat (w_bk_stat)
    );

    hbp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_q_valid),
        .i_item       (w_q_item),
        .o_stat       (w_bk_stat),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_data       (o_m_axis_tdata),
        .o_last       (o_m_axis_tlast)
    );

    `HBP_ASSERT_IMPLY(a_stall_cause, !o_s_axis_tready, w_fe_valid && !w_q_ready)
    `HBP_ASSERT_IMPLY(a_pop_nonempty, w_bk_stat.pop, w_q_valid)
    `HBP_ASSERT_IMPLY(a_more_bytes, o_m_axis_tvalid && !o_m_axis_tlast, w_bk_stat.busy)

endmodule
